// File: hdl/baro_temp_pressure_compensation_macros.svh
// Assertion macros shared by the compensation block.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define BTPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define BTPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BTPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/btpc_pkg.sv
package btpc_pkg;

    // Register indexes
    localparam logic [2:0] REG_T1_T2 = 3'd0;
    localparam logic [2:0] REG_T3_P1 = 3'd1;
    localparam logic [2:0] REG_P2_P3 = 3'd2;
    localparam logic [2:0] REG_P4_P5 = 3'd3;
    localparam logic [2:0] REG_P6_P7 = 3'd4;
    localparam logic [2:0] REG_P8_P9 = 3'd5;
    localparam int         NUM_REGS  = 6;

    // Compensation constants
    localparam logic signed [32:0] OFFSET_T    = 33'sd128000;
    localparam logic [11:0]        PRESS_SCALE = 12'd3125;
    localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
    localparam int                 SHIFT_ONE   = 47;
    localparam int                 SHIFT_P4    = 35;
    localparam logic signed [31:0] ROUND_T     = 32'sd128;

    // Calibration coefficients, unpacked from the registers
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } coef_t;

    // Temperature results that ride along with the pressure path
    typedef struct packed {
        logic signed [31:0] fine;
        logic signed [23:0] centi;
    } temp_res_t;

endpackage

// File: hdl/btpc_temp.sv
// Temperature compensation, five stages, 32-bit wrapping.
module btpc_temp import btpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [19:0] raw_t,
    input  logic [19:0] raw_p,
    input  coef_t       coef,
    output logic        out_valid,
    output temp_res_t   res,
    output logic [19:0] raw_p_out
);

    logic [4:0]         v_reg;
    logic [19:0]        rp_reg [0:4];
    logic signed [17:0] d1_reg, d1_next;
    logic signed [16:0] d2_reg, d2_next;
    logic signed [31:0] m1_reg, m1_next, sq_reg, sq_next;
    logic signed [31:0] ta_reg, ta_next, m2_reg, m2_next;
    logic signed [31:0] tf_reg, tf_next, fine_reg;
    logic signed [23:0] centi_reg, centi_next;
    logic signed [33:0] m1_full, sq_full;
    logic signed [31:0] sqs, tf5, tc32;
    logic signed [47:0] m2_full;

    // stage math
    always_comb begin
        d1_next = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
        d2_next = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, coef.t1});
        m1_full = d1_reg * coef.t2;
        sq_full = d2_reg * d2_reg;
        m1_next = m1_full[31:0];
        sq_next = sq_full[31:0];
        ta_next = m1_reg >>> 11;
        sqs     = sq_reg >>> 12;
        m2_full = sqs * coef.t3;
        m2_next = m2_full[31:0];
        tf_next = ta_reg + (m2_reg >>> 14);
        tf5     = (tf_reg <<< 2) + tf_reg + ROUND_T;
        tc32    = tf5 >>> 8;
        centi_next = tc32[23:0];
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            rp_reg[0] <= raw_p;
            for (int i = 1; i < 5; i++) rp_reg[i] <= rp_reg[i-1];
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            m1_reg    <= m1_next;
            sq_reg    <= sq_next;
            ta_reg    <= ta_next;
            m2_reg    <= m2_next;
            tf_reg    <= tf_next;
            fine_reg  <= tf_reg;
            centi_reg <= centi_next;
        end
    end

    assign out_valid = v_reg[4];
    assign res.fine  = fine_reg;
    assign res.centi = centi_reg;
    assign raw_p_out = rp_reg[4];

endmodule

// File: hdl/btpc_coef.sv
// Pressure prefactors: numerator and divisor, seven stages, 64-bit wrapping.
module btpc_coef import btpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  logic        in_valid,
    input  temp_res_t   res_in,
    input  logic [19:0] raw_p,
    input  coef_t       coef,
    output logic        out_valid,
    output temp_res_t   res_out,
    output logic [63:0] num,
    output logic signed [30:0] den
);

    logic [6:0]         v_reg;
    temp_res_t          res_reg [0:6];
    logic [20:0]        pn_reg [1:4];
    logic [20:0]        pn_next;
    logic signed [32:0] a_reg, a_next;
    logic signed [65:0] aa_full;
    logic [63:0]        aa_reg, aa_next;
    logic signed [48:0] ap5_reg [2:3];
    logic signed [48:0] ap2_reg [2:4];
    logic signed [48:0] ap5_next, ap2_next;
    logic signed [48:0] lo6_reg, lo6_next, lo3_reg, lo3_next;
    logic [31:0]        hi6_reg, hi6_next, hi3_reg, hi3_next;
    logic [63:0]        b_reg, b_next, t3_reg, t3_next;
    logic [63:0]        x_reg, x_next, n1_reg, n1_next;
    logic [47:0]        xlo_reg, xlo_next;
    logic [31:0]        xhi_reg, xhi_next, nhi_reg, nhi_next;
    logic [43:0]        nlo_reg, nlo_next;
    logic [63:0]        num_reg, num_next, dprod;
    logic signed [30:0] den_reg, den_next;

    always_comb begin
        // C1: offset temperature, pressure base
        a_next   = 33'(res_in.fine) - OFFSET_T;
        pn_next  = PRESS_BASE - 21'(raw_p);
        // C2: square and linear terms
        aa_full  = a_reg * a_reg;
        aa_next  = aa_full[63:0];
        ap5_next = a_reg * coef.p5;
        ap2_next = a_reg * coef.p2;
        // C3: square times P6 and P3, split in halves
        lo6_next = $signed({1'b0, aa_reg[31:0]}) * coef.p6;
        hi6_next = aa_reg[63:32] * 32'(coef.p6);
        lo3_next = $signed({1'b0, aa_reg[31:0]}) * coef.p3;
        hi3_next = aa_reg[63:32] * 32'(coef.p3);
        // C4: var2 sum and var1 square term
        b_next   = 64'(lo6_reg) + {hi6_reg, 32'b0} + (64'(ap5_reg[3]) << 17)
                 + (64'(coef.p4) << SHIFT_P4);
        t3_next  = 64'(lo3_reg) + {hi3_reg, 32'b0};
        // C5: var1 before P1, numerator before scale
        x_next   = 64'($signed(t3_reg) >>> 8) + (64'(ap2_reg[4]) << 12)
                 + (64'd1 << SHIFT_ONE);
        n1_next  = (64'(pn_reg[4]) << 31) - b_reg;
        // C6: partial products
        xlo_next = x_reg[31:0] * coef.p1;
        xhi_next = x_reg[63:32] * 32'(coef.p1);
        nlo_next = n1_reg[31:0] * PRESS_SCALE;
        nhi_next = n1_reg[63:32] * 32'(PRESS_SCALE);
        // C7: recombine
        num_next = 64'(nlo_reg) + {nhi_reg, 32'b0};
        dprod    = 64'(xlo_reg) + {xhi_reg, 32'b0};
        den_next = dprod[63:33];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg[0] <= res_in;
            for (int i = 1; i < 7; i++) res_reg[i] <= res_reg[i-1];
            pn_reg[1]  <= pn_next;
            for (int i = 2; i < 5; i++) pn_reg[i] <= pn_reg[i-1];
            a_reg      <= a_next;
            aa_reg     <= aa_next;
            ap5_reg[2] <= ap5_next;
            ap5_reg[3] <= ap5_reg[2];
            ap2_reg[2] <= ap2_next;
            ap2_reg[3] <= ap2_reg[2];
            ap2_reg[4] <= ap2_reg[3];
            lo6_reg    <= lo6_next;
            hi6_reg    <= hi6_next;
            lo3_reg    <= lo3_next;
            hi3_reg    <= hi3_next;
            b_reg      <= b_next;
            t3_reg     <= t3_next;
            x_reg      <= x_next;
            n1_reg     <= n1_next;
            xlo_reg    <= xlo_next;
            xhi_reg    <= xhi_next;
            nlo_reg    <= nlo_next;
            nhi_reg    <= nhi_next;
            num_reg    <= num_next;
            den_reg    <= den_next;
        end
    end

    assign out_valid = v_reg[6];
    assign res_out   = res_reg[6];
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

// File: hdl/btpc_div.sv
// Pipelined signed divide, one quotient bit per stage, truncating toward zero.
module btpc_div import btpc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  temp_res_t          res_in,
    input  logic [63:0]        num,
    input  logic signed [30:0] den,
    output logic               out_valid,
    output temp_res_t          res_out,
    output logic               zero,
    output logic [63:0]        quot
);

    typedef struct packed {
        temp_res_t   res;
        logic        qneg;
        logic        zero;
        logic [30:0] md;
    } div_side_t;

    // index 0 is the magnitude stage, 1..64 the bit steps
    logic [64:0] v_reg;
    div_side_t   side_reg [0:64];
    logic [30:0] rem_reg  [0:64];
    logic [63:0] nq_reg   [0:64];
    logic [63:0] quot_reg;
    div_side_t   side_out_reg;
    logic        vout_reg;
    div_side_t   side0_next;

    // magnitudes and signs
    always_comb begin
        side0_next.res  = res_in;
        side0_next.qneg = num[63] ^ den[30];
        side0_next.zero = (den == '0);
        side0_next.md   = den[30] ? 31'(-den) : 31'(den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= '0;
            vout_reg <= 1'b0;
        end else if (adv) begin
            v_reg    <= {v_reg[63:0], in_valid};
            vout_reg <= v_reg[64];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side0_next;
            rem_reg[0]  <= '0;
            nq_reg[0]   <= num[63] ? (64'd0 - num) : num;
        end
    end

    // restoring steps
    for (genvar k = 1; k <= 64; k++) begin : g_step
        logic [31:0] r2;
        logic        ge;
        logic [31:0] diff;
        logic [30:0] rem_next;
        logic [63:0] nq_next;

        always_comb begin
            r2       = {rem_reg[k-1], nq_reg[k-1][63]};
            ge       = (r2 >= {1'b0, side_reg[k-1].md});
            diff     = r2 - {1'b0, side_reg[k-1].md};
            rem_next = ge ? diff[30:0] : r2[30:0];
            nq_next  = {nq_reg[k-1][62:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[k] <= side_reg[k-1];
                rem_reg[k]  <= rem_next;
                nq_reg[k]   <= nq_next;
            end
        end
    end

    // sign fix
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_out_reg <= side_reg[64];
            quot_reg     <= side_reg[64].qneg ? (64'd0 - nq_reg[64]) : nq_reg[64];
        end
    end

    assign out_valid = vout_reg;
    assign res_out   = side_out_reg.res;
    assign zero      = side_out_reg.zero;
    assign quot      = quot_reg;

endmodule

// File: hdl/btpc_post.sv
// Pressure post-correction and saturation, seven stages; last stage is the output register.
module btpc_post import btpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  logic        in_valid,
    input  temp_res_t   res_in,
    input  logic        zero_in,
    input  logic [63:0] quot,
    input  coef_t       coef,
    output logic        out_valid,
    output temp_res_t   res_out,
    output logic [31:0] pressure,
    output logic        pressure_ok
);

    logic [6:0]         v_reg;
    temp_res_t          res_reg  [0:6];
    logic               zero_reg [0:5];
    logic [63:0]        p_reg    [0:3];
    logic [63:0]        bb_reg   [1:3];
    logic [63:0]        q;
    logic [63:0]        mll_reg, mll_next;
    logic [31:0]        mlh_reg, mlh_next;
    logic signed [48:0] p8lo_reg, p8lo_next;
    logic [31:0]        p8hi_reg, p8hi_next;
    logic [63:0]        qq_reg, qq_next, bsum, bb_next;
    logic signed [48:0] lo9_reg, lo9_next;
    logic [31:0]        hi9_reg, hi9_next;
    logic [63:0]        asum, aa_reg, aa_next;
    logic [63:0]        sum_reg, sum_next, s_reg, s_next;
    logic [31:0]        pres_reg, pres_next;
    logic               ok_reg;

    always_comb begin
        // P1: square of p>>13 and P8 term, in halves
        q         = 64'($signed(quot) >>> 13);
        mll_next  = q[31:0] * q[31:0];
        mlh_next  = q[31:0] * q[63:32];
        p8lo_next = $signed({1'b0, quot[31:0]}) * coef.p8;
        p8hi_next = quot[63:32] * 32'(coef.p8);
        // P2: recombine
        qq_next   = mll_reg + {mlh_reg[30:0], 33'b0};
        bsum      = 64'(p8lo_reg) + {p8hi_reg, 32'b0};
        bb_next   = 64'($signed(bsum) >>> 19);
        // P3: P9 term, in halves
        lo9_next  = $signed({1'b0, qq_reg[31:0]}) * coef.p9;
        hi9_next  = qq_reg[63:32] * 32'(coef.p9);
        // P4
        asum      = 64'(lo9_reg) + {hi9_reg, 32'b0};
        aa_next   = 64'($signed(asum) >>> 25);
        // P5, P6
        sum_next  = p_reg[3] + aa_reg + bb_reg[3];
        s_next    = 64'($signed(sum_reg) >>> 8) + (64'(coef.p7) << 4);
        // P7: clamp to 0..2^32-1, zero divisor forces 0
        if (zero_reg[5] || s_reg[63]) begin
            pres_next = '0;
        end else if (|s_reg[62:32]) begin
            pres_next = '1;
        end else begin
            pres_next = s_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg[0]  <= res_in;
            for (int i = 1; i < 7; i++) res_reg[i] <= res_reg[i-1];
            zero_reg[0] <= zero_in;
            for (int i = 1; i < 6; i++) zero_reg[i] <= zero_reg[i-1];
            p_reg[0]    <= quot;
            for (int i = 1; i < 4; i++) p_reg[i] <= p_reg[i-1];
            bb_reg[1]   <= bb_next;
            bb_reg[2]   <= bb_reg[1];
            bb_reg[3]   <= bb_reg[2];
            mll_reg     <= mll_next;
            mlh_reg     <= mlh_next;
            p8lo_reg    <= p8lo_next;
            p8hi_reg    <= p8hi_next;
            qq_reg      <= qq_next;
            lo9_reg     <= lo9_next;
            hi9_reg     <= hi9_next;
            aa_reg      <= aa_next;
            sum_reg     <= sum_next;
            s_reg       <= s_next;
            pres_reg    <= pres_next;
            ok_reg      <= !zero_reg[5];
        end
    end

    assign out_valid   = v_reg[6];
    assign res_out     = res_reg[6];
    assign pressure    = pres_reg;
    assign pressure_ok = ok_reg;

endmodule

// File: hdl/baro_temp_pressure_compensation.sv
// Barometric temperature and pressure compensation.
// Input channel s_*: one beat carries a 20-bit raw temperature and a 20-bit
// raw pressure sample. Output channel m_*: one beat per input beat, in order,
// with fine temperature, temperature in 0.01 degC, pressure in Q24.8 Pa and a
// flag that is low when the pressure divisor came out zero (pressure then 0).
// Calibration lives in six 32-bit registers written through cfg_we, cfg_index
// and cfg_wdata; write them only while no beat is in flight.
// Pipeline: 5 temperature stages, 7 prefactor stages, 66 divider stages (one
// quotient bit per stage over the 64-bit numerator) and 7 post-correction
// stages. Throughput is one beat per cycle while m_ready does not stall it.
// The whole pipeline advances together; when the output register holds a beat
// that m_ready does not take, every stage holds and s_ready drops. Empty
// output, or a taken beat, lets a new beat enter in the same cycle.
// Synchronous reset clears all valid bits and the calibration registers.
`include "baro_temp_pressure_compensation_macros.svh"
module baro_temp_pressure_compensation import btpc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [19:0]        s_raw_temperature,
    input  logic [19:0]        s_raw_pressure,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_fine_temperature,
    output logic signed [23:0] m_temperature_centi,
    output logic [31:0]        m_pressure_q24_8,
    output logic               m_pressure_valid,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);

    logic [31:0]        cfg_reg [0:NUM_REGS-1];
    coef_t              coef;
    logic               adv;
    logic               tmp_valid, cf_valid, dv_valid;
    temp_res_t          tmp_res, cf_res, dv_res, out_res;
    logic [19:0]        tmp_raw_p;
    logic [63:0]        cf_num, dv_quot;
    logic signed [30:0] cf_den;
    logic               dv_zero;

    // calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) cfg_reg[i] <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_T1_T2: cfg_reg[REG_T1_T2] <= cfg_wdata;
                REG_T3_P1: cfg_reg[REG_T3_P1] <= cfg_wdata;
                REG_P2_P3: cfg_reg[REG_P2_P3] <= cfg_wdata;
                REG_P4_P5: cfg_reg[REG_P4_P5] <= cfg_wdata;
                REG_P6_P7: cfg_reg[REG_P6_P7] <= cfg_wdata;
                REG_P8_P9: cfg_reg[REG_P8_P9] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        coef.t1 = cfg_reg[REG_T1_T2][15:0];
        coef.t2 = cfg_reg[REG_T1_T2][31:16];
        coef.t3 = cfg_reg[REG_T3_P1][15:0];
        coef.p1 = cfg_reg[REG_T3_P1][31:16];
        coef.p2 = cfg_reg[REG_P2_P3][15:0];
        coef.p3 = cfg_reg[REG_P2_P3][31:16];
        coef.p4 = cfg_reg[REG_P4_P5][15:0];
        coef.p5 = cfg_reg[REG_P4_P5][31:16];
        coef.p6 = cfg_reg[REG_P6_P7][15:0];
        coef.p7 = cfg_reg[REG_P6_P7][31:16];
        coef.p8 = cfg_reg[REG_P8_P9][15:0];
        coef.p9 = cfg_reg[REG_P8_P9][31:16];
    end

    // global advance
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    btpc_temp u_temp (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(s_valid),
        .raw_t(s_raw_temperature), .raw_p(s_raw_pressure), .coef(coef),
        .out_valid(tmp_valid), .res(tmp_res), .raw_p_out(tmp_raw_p)
    );

    btpc_coef u_coef (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(tmp_valid),
        .res_in(tmp_res), .raw_p(tmp_raw_p), .coef(coef),
        .out_valid(cf_valid), .res_out(cf_res), .num(cf_num), .den(cf_den)
    );

    btpc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(cf_valid),
        .res_in(cf_res), .num(cf_num), .den(cf_den),
        .out_valid(dv_valid), .res_out(dv_res), .zero(dv_zero), .quot(dv_quot)
    );

    btpc_post u_post (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(dv_valid),
        .res_in(dv_res), .zero_in(dv_zero), .quot(dv_quot), .coef(coef),
        .out_valid(m_valid), .res_out(out_res), .pressure(m_pressure_q24_8),
        .pressure_ok(m_pressure_valid)
    );

    assign m_fine_temperature  = out_res.fine;
    assign m_temperature_centi = out_res.centi;

    // zero divisor always reports zero pressure
    `BTPC_ASSERT_IMPL(a_zero_press, aclk, aresetn, m_valid && !m_pressure_valid, m_pressure_q24_8 == '0)
    // a stall freezes the inner pipeline
    `BTPC_ASSERT_NEXT(a_stall_hold, aclk, aresetn, !adv, $stable(tmp_valid) && $stable(dv_valid))
    // reset empties the output
    `BTPC_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid)

endmodule
